// ===== src/vcrd_pkg.sv =====
// vcrd_pkg: shared constants, types and helpers of the vector clock race detector
// no dependencies; used by every module under src except vcrd_ram

package vcrd_pkg;

    localparam int NUM_THREADS   = 8;
    localparam int NUM_LOCKS     = 16;
    localparam int NUM_LOCATIONS = 256;
    localparam int CLOCK_BITS    = 32;

    // fixed field widths of the stream items
    localparam int OP_W      = 3;
    localparam int TID_W     = 3;
    localparam int LID_W     = 4;
    localparam int LOC_W     = 8;
    localparam int MASK_W    = 8;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    localparam int LOCK_AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int LOC_AW  = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
    localparam int ROW_W   = NUM_THREADS * CLOCK_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_LOCAL   = 3'd0,
        OP_READ    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_ACQUIRE = 3'd3,
        OP_RELEASE = 3'd4
    } t_op;

    typedef logic [CLOCK_BITS-1:0] t_clk;
    typedef t_clk [NUM_THREADS-1:0] t_row;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [TID_W-1:0] tid;
        logic [LID_W-1:0] lid;
        logic [LOC_W-1:0] loc;
    } t_item;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // latch the item and start the row reads
        logic exec;   // update the clocks and load the result register
    } t_dp_cmd;

    function automatic t_clk clk_max(input t_clk a, input t_clk b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== src/vcrd_ram.sv =====
// vcrd_ram: generic single write port, single read port ram with registered read
// no dependencies

module vcrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/vcrd_ctrl.sv =====
// vcrd_ctrl: two-state controller and output valid flag of the race detector
// depends on vcrd_pkg

module vcrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output vcrd_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // one result slot: take an item only when the slot is free or draining
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/vcrd_dp.sv =====
// vcrd_dp: clock stores, merge and compare logic and result register
// depends on vcrd_pkg and vcrd_ram

module vcrd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vcrd_pkg::t_dp_cmd             i_cmd,
    input  vcrd_pkg::t_item               i_item,
    output logic                          o_race,
    output logic [vcrd_pkg::MASK_W-1:0]   o_mask
);

    // thread clock rows in flops, every entry reset to one
    vcrd_pkg::t_row r_thr [vcrd_pkg::NUM_THREADS];
    logic           r_lock_vld [vcrd_pkg::NUM_LOCKS];
    logic           r_loc_vld  [vcrd_pkg::NUM_LOCATIONS];

    logic [vcrd_pkg::OP_W-1:0]  r_op;
    logic [vcrd_pkg::TID_W-1:0] r_tid;
    logic [vcrd_pkg::LID_W-1:0] r_lid;
    logic [vcrd_pkg::LOC_W-1:0] r_loc;
    logic                       r_race;
    logic [vcrd_pkg::MASK_W-1:0] r_mask;

    logic [vcrd_pkg::ROW_W-1:0]   w_lock_rdata;
    logic [2*vcrd_pkg::ROW_W-1:0] w_loc_rdata;

    vcrd_pkg::t_row w_tv, w_tv_tick, w_tv_acq;
    vcrd_pkg::t_row w_lock_row, w_lock_new;
    vcrd_pkg::t_row w_rd_row, w_wr_row, w_rd_new, w_wr_new;
    vcrd_pkg::t_clk w_own;
    logic [vcrd_pkg::NUM_THREADS-1:0] w_bad;
    logic [vcrd_pkg::MASK_W-1:0]      w_mask;
    logic w_thr_ok, w_lock_ok, w_loc_ok;
    logic w_is_local, w_is_rw, w_is_write, w_is_acq, w_is_rel;
    logic w_thr_we, w_lock_we, w_loc_we;

    vcrd_ram #(
        .WIDTH (vcrd_pkg::ROW_W),
        .DEPTH (vcrd_pkg::NUM_LOCKS)
    ) u_lock_ram (
        .i_clk   (i_clk),
        .i_we    (w_lock_we),
        .i_waddr (r_lid[vcrd_pkg::LOCK_AW-1:0]),
        .i_wdata (w_lock_new),
        .i_re    (i_cmd.load),
        .i_raddr (i_item.lid[vcrd_pkg::LOCK_AW-1:0]),
        .o_rdata (w_lock_rdata)
    );

    // location row: write vector above read vector
    vcrd_ram #(
        .WIDTH (2 * vcrd_pkg::ROW_W),
        .DEPTH (vcrd_pkg::NUM_LOCATIONS)
    ) u_loc_ram (
        .i_clk   (i_clk),
        .i_we    (w_loc_we),
        .i_waddr (r_loc[vcrd_pkg::LOC_AW-1:0]),
        .i_wdata ({w_wr_new, w_rd_new}),
        .i_re    (i_cmd.load),
        .i_raddr (i_item.loc[vcrd_pkg::LOC_AW-1:0]),
        .o_rdata (w_loc_rdata)
    );

    always_comb begin
        w_thr_ok  = int'(r_tid) < vcrd_pkg::NUM_THREADS;
        w_lock_ok = int'(r_lid) < vcrd_pkg::NUM_LOCKS;
        w_loc_ok  = int'(r_loc) < vcrd_pkg::NUM_LOCATIONS;

        w_is_local = (r_op == vcrd_pkg::OP_LOCAL);
        w_is_write = (r_op == vcrd_pkg::OP_WRITE);
        w_is_rw    = (r_op == vcrd_pkg::OP_READ) || w_is_write;
        w_is_acq   = (r_op == vcrd_pkg::OP_ACQUIRE);
        w_is_rel   = (r_op == vcrd_pkg::OP_RELEASE);

        w_tv  = r_thr[r_tid];
        w_own = w_tv[r_tid];
        // saturating tick of the own entry
        w_tv_tick        = w_tv;
        w_tv_tick[r_tid] = (w_own == '1) ? w_own : w_own + vcrd_pkg::CLOCK_BITS'(1);

        // rows never written read as zero
        w_lock_row = r_lock_vld[r_lid] ? vcrd_pkg::t_row'(w_lock_rdata) : '0;
        w_rd_row   = r_loc_vld[r_loc]
                   ? vcrd_pkg::t_row'(w_loc_rdata[vcrd_pkg::ROW_W-1:0]) : '0;
        w_wr_row   = r_loc_vld[r_loc]
                   ? vcrd_pkg::t_row'(w_loc_rdata[2*vcrd_pkg::ROW_W-1:vcrd_pkg::ROW_W])
                   : '0;

        w_rd_new = w_rd_row;
        w_wr_new = w_wr_row;
        if (w_is_write) begin
            w_wr_new[r_tid] = w_tv[r_tid];
        end else begin
            w_rd_new[r_tid] = w_tv[r_tid];
        end

        for (int i = 0; i < vcrd_pkg::NUM_THREADS; i++) begin
            w_tv_acq[i]   = vcrd_pkg::clk_max(w_tv[i], w_lock_row[i]);
            w_lock_new[i] = vcrd_pkg::clk_max(w_tv_tick[i], w_lock_row[i]);
            w_bad[i]      = (w_wr_new[i] > w_tv[i]) || (w_is_write && (w_rd_new[i] > w_tv[i]));
        end

        w_mask = '0;
        for (int i = 0; i < vcrd_pkg::MASK_W; i++) begin
            if (i < vcrd_pkg::NUM_THREADS) begin
                w_mask[i] = w_bad[i];
            end
        end

        w_thr_we  = i_cmd.exec && w_thr_ok
                  && (w_is_local || ((w_is_acq || w_is_rel) && w_lock_ok));
        w_lock_we = i_cmd.exec && w_thr_ok && w_is_rel && w_lock_ok;
        w_loc_we  = i_cmd.exec && w_thr_ok && w_is_rw && w_loc_ok;
    end

    // thread rows and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vcrd_pkg::NUM_THREADS; i++) begin
                for (int j = 0; j < vcrd_pkg::NUM_THREADS; j++) begin
                    r_thr[i][j] <= vcrd_pkg::CLOCK_BITS'(1);
                end
            end
            for (int i = 0; i < vcrd_pkg::NUM_LOCKS; i++) begin
                r_lock_vld[i] <= 1'b0;
            end
            for (int i = 0; i < vcrd_pkg::NUM_LOCATIONS; i++) begin
                r_loc_vld[i] <= 1'b0;
            end
        end else begin
            if (w_thr_we) begin
                r_thr[r_tid] <= w_is_acq ? w_tv_acq : w_tv_tick;
            end
            if (w_lock_we) begin
                r_lock_vld[r_lid] <= 1'b1;
            end
            if (w_loc_we) begin
                r_loc_vld[r_loc] <= 1'b1;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.op;
            r_tid <= i_item.tid;
            r_lid <= i_item.lid;
            r_loc <= i_item.loc;
        end
        if (i_cmd.exec) begin
            r_race <= w_thr_ok && w_is_rw && w_loc_ok && (|w_bad);
            r_mask <= (w_thr_ok && w_is_rw && w_loc_ok) ? w_mask : '0;
        end
    end

    assign o_race = r_race;
    assign o_mask = r_mask;

endmodule

// ===== src/vector_clock_race_detector_core.sv =====
// vector_clock_race_detector_core: top level of the happens-before race detector
// depends on vcrd_pkg, vcrd_ctrl, vcrd_dp (which holds two vcrd_ram instances)
//
// usage
//   input stream s_axis: one item per operation (local event, read, write,
//   lock acquire, lock release) naming a thread, a lock and a location
//   output stream m_axis: exactly one result item per input item, in order,
//   carrying the race flag and the per-thread mask of offending threads
//   the lock and location rows live in rams with registered read, so an item is
//   taken with a load step that reads its rows, then an exec step merges, compares
//   and writes them back and loads the result; no new item is taken until the
//   exec step is done
//   reset (i_rst_n low, synchronous): every thread clock entry goes to one, the valid
//   bits of every lock and location row clear so those rows read as zero;
//   no clearing pass, the block takes items right after reset
//   stall: a result waiting on m_axis holds its payload; while it is not
//   taken the next item can still be accepted only in the cycle it drains,
//   otherwise s_axis_tready stays low

module vector_clock_race_detector_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] operation, [5:3] thread_id, [9:6] lock_id, [17:10] location_id
    input  logic [vcrd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] race, [8:1] offending_threads
    output logic [vcrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    vcrd_pkg::t_dp_cmd w_cmd;
    vcrd_pkg::t_item   w_item;
    logic              w_race;
    logic [vcrd_pkg::MASK_W-1:0] w_mask;

    // unpack the input fields, lowest first
    assign w_item.op  = s_axis_tdata[2:0];
    assign w_item.tid = s_axis_tdata[5:3];
    assign w_item.lid = s_axis_tdata[9:6];
    assign w_item.loc = s_axis_tdata[17:10];

    vcrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    vcrd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (w_item),
        .o_race  (w_race),
        .o_mask  (w_mask)
    );

    // pack the result, padded to whole bytes
    assign m_axis_tdata = {7'b0, w_mask, w_race};

endmodule

// ===== tb/vcrd_race_checker.sv =====
`timescale 1ns / 100ps
// vcrd_race_checker: watches both streams of the race detector, predicts each result
// from its own copy of the thread, lock and location clocks and compares; needs vcrd_pkg

module vcrd_race_checker
    import vcrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // [2:0] operation, [5:3] thread_id, [9:6] lock_id, [17:10] location_id
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] race, [8:1] offending_threads
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_race_count
);

    typedef struct packed {
        logic              race;
        logic [MASK_W-1:0] offenders;
    } t_race_report;

    t_clk thread_vc [NUM_THREADS][NUM_THREADS];
    t_clk lock_vc   [NUM_LOCKS][NUM_THREADS];
    t_clk read_vc   [NUM_LOCATIONS][NUM_THREADS];
    t_clk write_vc  [NUM_LOCATIONS][NUM_THREADS];

    t_race_report expected_reports [$];
    int fail_count = 0;
    int race_count = 0;
    int results_seen = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t ns: result %0d, %s: got %0h, expected %0h",
                 $time, results_seen, what, got, want);
    endtask

    // own entry plus one, held at the top value
    function automatic void advance_own(input int t);
        if (thread_vc[t][t] != '1)
            thread_vc[t][t] = thread_vc[t][t] + t_clk'(1);
    endfunction

    function automatic t_race_report apply_item(input logic [IN_DATA_W-1:0] data);
        logic [OP_W-1:0]  op;
        logic [TID_W-1:0] tid;
        logic [LID_W-1:0] lid;
        logic [LOC_W-1:0] loc;
        t_race_report     rep;
        int               t, l, a;
        op  = data[2:0];
        tid = data[5:3];
        lid = data[9:6];
        loc = data[17:10];
        rep = '0;
        t = int'(tid);
        l = int'(lid);
        a = int'(loc);
        if (t >= NUM_THREADS)
            return rep;
        case (op)
            OP_LOCAL: begin
                advance_own(t);
            end
            OP_READ, OP_WRITE: begin
                if (a < NUM_LOCATIONS) begin
                    if (op == OP_READ)
                        read_vc[a][t] = thread_vc[t][t];
                    else
                        write_vc[a][t] = thread_vc[t][t];
                    for (int i = 0; i < NUM_THREADS; i++) begin
                        if (write_vc[a][i] > thread_vc[t][i] ||
                            (op == OP_WRITE && read_vc[a][i] > thread_vc[t][i])) begin
                            rep.race = 1'b1;
                            if (i < MASK_W)
                                rep.offenders[i] = 1'b1;
                        end
                    end
                end
            end
            OP_ACQUIRE: begin
                if (l < NUM_LOCKS)
                    for (int i = 0; i < NUM_THREADS; i++)
                        if (lock_vc[l][i] > thread_vc[t][i])
                            thread_vc[t][i] = lock_vc[l][i];
            end
            OP_RELEASE: begin
                if (l < NUM_LOCKS) begin
                    advance_own(t);
                    for (int i = 0; i < NUM_THREADS; i++)
                        if (thread_vc[t][i] > lock_vc[l][i])
                            lock_vc[l][i] = thread_vc[t][i];
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_race_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++)
                for (int j = 0; j < NUM_THREADS; j++)
                    thread_vc[i][j] = t_clk'(1);
            for (int i = 0; i < NUM_LOCKS; i++)
                for (int j = 0; j < NUM_THREADS; j++)
                    lock_vc[i][j] = '0;
            for (int i = 0; i < NUM_LOCATIONS; i++)
                for (int j = 0; j < NUM_THREADS; j++) begin
                    read_vc[i][j]  = '0;
                    write_vc[i][j] = '0;
                end
            expected_reports.delete();
        end else begin
            // a result leaving now belongs to an earlier item, so check before predicting
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with no item waiting", 32'(m_axis_tdata), 0);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_axis_tdata[0] !== want.race)
                        report_mismatch("race", 32'(m_axis_tdata[0]), 32'(want.race));
                    if (m_axis_tdata[8:1] !== want.offenders)
                        report_mismatch("offending_threads", 32'(m_axis_tdata[8:1]),
                                        32'(want.offenders));
                    if (m_axis_tdata[OUT_DATA_W-1:9] !== '0)
                        report_mismatch("padding", 32'(m_axis_tdata[OUT_DATA_W-1:9]), 0);
                    if (want.race)
                        race_count++;
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_reports.push_back(apply_item(s_axis_tdata));
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fail_count;
        o_race_count <= race_count;
    end

endmodule

// ===== tb/vector_clock_race_detector_core_tb.sv =====
`timescale 1ns / 100ps
// vector_clock_race_detector_core_tb: stimulus, stalls and verdict for the race detector
// depends on vcrd_pkg, vector_clock_race_detector_core and vcrd_race_checker

module vector_clock_race_detector_core_tb;
    import vcrd_pkg::*;

    // items that touch clocks; unknown operations come on top
    localparam int WORK_ITEMS      = 1520;
    localparam int MAX_GAP         = 17;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 4000;
    localparam int LAST_OP         = (1 << OP_W) - 1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int race_count;
    int quiet_cycles = 0;
    int work_items = 0;
    int op_counts [1 << OP_W];
    // when set, the side in question runs back to back with no idle cycles
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    vector_clock_race_detector_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    vcrd_race_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_race_count  (race_count)
    );

    // offer one item after a random gap and hold it until the block takes it;
    // tvalid stays high on return so a back-to-back item needs no second assignment
    task automatic issue_op(input int op, input int tid, input int lid, input int loc);
        int                   gap;
        logic [IN_DATA_W-1:0] word;
        gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
        word = '0;
        word[2:0]   = op[2:0];
        word[5:3]   = tid[2:0];
        word[9:6]   = lid[3:0];
        word[17:10] = loc[7:0];
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        op_counts[op[2:0]]++;
        if (op <= int'(OP_RELEASE))
            work_items++;
    endtask

    // stop offering and wait until every predicted result has come back;
    // the pending count is registered, so always step at least once
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // a random read or write
    function automatic int any_access();
        return ($urandom_range(0, 1) == 0) ? int'(OP_READ) : int'(OP_WRITE);
    endfunction

    // result side: random stalls, runs of steady taking and one long hold-off
    // while the sender keeps offering, so the block backs up onto its input
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == HOLD_OFF_AT)
                gap = HOLD_OFF_CYCLES;
            else
                gap = take_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
            if (taken % 64 == 0)
                take_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog: too long without any item moving on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int round;
        int choice;
        int thr;
        int lk;
        int n;
        int unknown_ops;
        round = 0;
        unknown_ops = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // every field at all ones on a local event, then all zeros
        issue_op(OP_LOCAL, 7, 15, 255);
        issue_op(OP_LOCAL, 0, 0, 0);
        // thread 0 writes ahead of thread 1's view: read race and write race on bit 0
        issue_op(OP_WRITE, 0, 3, 0);
        issue_op(OP_READ, 1, 0, 0);
        issue_op(OP_WRITE, 1, 0, 0);
        // same on the top thread and the last location: race on bit 7
        issue_op(OP_WRITE, 7, 0, 255);
        issue_op(OP_WRITE, 6, 15, 255);
        issue_op(OP_READ, 6, 0, 255);
        // release then acquire of the last lock orders thread 2 before thread 3
        issue_op(OP_LOCAL, 2, 0, 99);
        issue_op(OP_WRITE, 2, 0, 17);
        issue_op(OP_RELEASE, 2, 15, 0);
        issue_op(OP_ACQUIRE, 3, 15, 0);
        issue_op(OP_READ, 3, 0, 17);
        issue_op(OP_WRITE, 3, 0, 17);
        // lock 0 handoff, then a read and a write at one location that flag no race
        issue_op(OP_RELEASE, 5, 0, 128);
        issue_op(OP_ACQUIRE, 4, 0, 128);
        issue_op(OP_READ, 4, 9, 128);
        issue_op(OP_WRITE, 5, 9, 128);
        // acquire of a lock never released changes nothing
        issue_op(OP_ACQUIRE, 6, 9, 170);
        // write after an unordered read: read vector is compared too
        issue_op(OP_READ, 1, 5, 85);
        issue_op(OP_LOCAL, 1, 5, 85);
        issue_op(OP_READ, 1, 5, 85);
        issue_op(OP_WRITE, 0, 10, 85);
        // unknown operations change nothing
        for (int c = OP_RELEASE + 1; c <= LAST_OP; c++) begin
            issue_op(c, 7, 15, 255);
            issue_op(c, 0, 0, 0);
        end
        wait_for_results();

        // --- random part ---
        while (work_items < WORK_ITEMS) begin
            if (round % 40 == 0)
                send_steady = ($urandom_range(0, 3) == 0);
            // pause now and then until the block has answered everything
            if (round % 150 == 149)
                wait_for_results();
            round++;
            choice = $urandom_range(0, 99);
            thr = $urandom_range(0, NUM_THREADS - 1);
            lk = $urandom_range(0, 3);
            if (choice < 55) begin
                // guarded section: locations lk*16 .. lk*16+3 belong to lock lk
                issue_op(OP_ACQUIRE, thr, lk, $urandom_range(0, 255));
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0)
                        issue_op(OP_LOCAL, thr, $urandom_range(0, 15), $urandom_range(0, 255));
                    else
                        issue_op(any_access(), thr, $urandom_range(0, 15),
                                 lk * 16 + $urandom_range(0, 3));
                end
                issue_op(OP_RELEASE, thr, lk, $urandom_range(0, 255));
            end else if (choice < 75) begin
                // unguarded access to a guarded location, the usual source of races
                issue_op(any_access(), thr, $urandom_range(0, 15),
                         $urandom_range(0, 3) * 16 + $urandom_range(0, 3));
            end else if (choice < 83) begin
                issue_op(OP_LOCAL, thr, $urandom_range(0, 15), $urandom_range(0, 255));
            end else if (choice < 90) begin
                // stray acquire or release on any lock
                issue_op(($urandom_range(0, 1) == 0) ? int'(OP_ACQUIRE) : int'(OP_RELEASE),
                         thr, $urandom_range(0, NUM_LOCKS - 1), $urandom_range(0, 255));
            end else if (choice < 95) begin
                issue_op($urandom_range(OP_RELEASE + 1, LAST_OP), thr,
                         $urandom_range(0, 15), $urandom_range(0, 255));
            end else begin
                // anything at all, over the whole location range
                issue_op($urandom_range(0, LAST_OP), thr,
                         $urandom_range(0, 15), $urandom_range(0, 255));
            end
        end

        wait_for_results();
        repeat (4) @(posedge i_clk);

        for (int c = OP_RELEASE + 1; c <= LAST_OP; c++)
            unknown_ops += op_counts[c];
        $display("items: %0d local, %0d read, %0d write, %0d acquire, %0d release, %0d unknown",
                 op_counts[OP_LOCAL], op_counts[OP_READ], op_counts[OP_WRITE],
                 op_counts[OP_ACQUIRE], op_counts[OP_RELEASE], unknown_ops);
        $display("%0d results flagged a race; long output stall and drain pauses included",
                 race_count);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
